[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[rtl/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg
// Types and constants shared by the clock page replacement core.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int FRAME_W   = 16;
   localparam int TYPE_W    = 2;
   localparam int OCC_W     = 7;
   localparam int CAP_W     = 7;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_VICTIM = 2'd2,
      REQ_UNUSED = 2'd3
   } crp_req_code_type;

   // Operation applied to the whole cell row in the same cycle.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_DELETE,
      CELL_APPEND,
      CELL_OVERWRITE
   } crp_op_type;

   typedef struct packed {
      logic               valid;
      logic               refd;
      logic [FRAME_W-1:0] frame;
   } crp_entry_type;

   typedef struct packed {
      crp_op_type         op;
      logic               refd;
      logic [FRAME_W-1:0] frame;
   } crp_cmd_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } crp_status_type;

endpackage

`default_nettype wire

[rtl/crp_cell.sv]
// ----------------------------------------------------------------------------
// crp_cell
// One ring position: frame id, reference bit and occupancy, shifted toward
// the head under command of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crp_pkg::crp_cmd_type   cmd,
   input  wire crp_pkg::crp_entry_type head,
   input  wire crp_pkg::crp_entry_type next,
   input  wire logic                  prev_valid,
   input  wire logic                  head_sel,
   output crp_pkg::crp_entry_type      entry
);
   import crp_pkg::*;

   logic               valid_ff, valid_in;
   logic               refd_ff, refd_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               tail;

   // last occupied cell of the row
   assign tail = valid_ff && !next.valid;

   always_comb begin
      valid_in = valid_ff;
      refd_in  = refd_ff;
      frame_in = frame_ff;
      case (cmd.op)
         CELL_ROTATE: begin
            if (tail) begin
               valid_in = 1'b1;
               refd_in  = cmd.refd;
               frame_in = head.frame;
            end else if (valid_ff) begin
               valid_in = next.valid;
               refd_in  = next.refd;
               frame_in = next.frame;
            end
         end
         CELL_DELETE: begin
            valid_in = next.valid;
            refd_in  = next.refd;
            frame_in = next.frame;
         end
         CELL_APPEND: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               refd_in  = 1'b0;
               frame_in = cmd.frame;
            end
         end
         CELL_OVERWRITE: begin
            if (head_sel) begin
               refd_in  = cmd.refd;
               frame_in = cmd.frame;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         refd_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         refd_ff  <= refd_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign entry.valid = valid_ff;
   assign entry.refd  = refd_ff;
   assign entry.frame = frame_ff;

endmodule

`default_nettype wire

[rtl/crp_ctrl.sv]
// ----------------------------------------------------------------------------
// crp_ctrl
// Request sequencer: scans the ring through the head cell, runs the hand
// sweep, holds capacity and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [crp_pkg::TYPE_W-1:0]     req_type,
   input  wire logic [crp_pkg::FRAME_W-1:0]    req_frame_id,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [crp_pkg::FRAME_W-1:0]         rsp_victim_frame,
   output logic                                rsp_victim_valid,
   output logic                                rsp_was_present,
   output logic [crp_pkg::OCC_W-1:0]           rsp_occupancy,
   input  wire logic                           csr_wr_en,
   input  wire logic [crp_pkg::CAP_W-1:0]      csr_wr_data,
   input  wire crp_pkg::crp_entry_type          head,
   output crp_pkg::crp_cmd_type                 cmd,
   output crp_pkg::crp_status_type              status
);
   import crp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   crp_req_code_type   kind_ff, kind_in;
   logic [FRAME_W-1:0] id_ff, id_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic               found_ff, found_in;
   logic               append_ff, append_in;
   logic [FRAME_W-1:0] vframe_ff, vframe_in;
   logic               vvalid_ff, vvalid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic               rsp_vvalid_ff, rsp_vvalid_in;
   logic               rsp_present_ff, rsp_present_in;
   logic [OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;

   logic accept;
   logic out_free;
   logic match;
   logic last_step;
   logic cap_ok;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign match     = head.valid && (head.frame == id_ff);
   assign last_step = (step_ff == (n_ff - CNT_W'(1)));
   assign cap_ok    = (count_ff < CNT_W'(NUM_SLOTS)) &&
                      (CMP_W'(count_ff) < CMP_W'(capacity_ff));

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      n_in           = n_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      capacity_in    = csr_wr_en ? csr_wr_data : capacity_ff;
      found_in       = found_ff;
      append_in      = append_ff;
      vframe_in      = vframe_ff;
      vvalid_in      = vvalid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_frame_in   = rsp_frame_ff;
      rsp_vvalid_in  = rsp_vvalid_ff;
      rsp_present_in = rsp_present_ff;
      rsp_occ_in     = rsp_occ_ff;
      cmd.op         = CELL_HOLD;
      cmd.refd       = 1'b0;
      cmd.frame      = id_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = crp_req_code_type'(req_type);
               id_in     = req_frame_id;
               n_in      = count_ff;
               step_in   = '0;
               found_in  = 1'b0;
               append_in = 1'b0;
               vframe_in = '0;
               vvalid_in = 1'b0;
               case (crp_req_code_type'(req_type))
                  REQ_INSERT: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end else begin
                        append_in = 1'b1;
                        state_in  = ST_FINISH;
                     end
                  end
                  REQ_REMOVE: begin
                     state_in = (count_ff != '0) ? ST_SCAN : ST_FINISH;
                  end
                  REQ_VICTIM: begin
                     state_in = (count_ff != '0) ? ST_SWEEP : ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // One ring entry passes the head per cycle; a full lap restores the hand.
         ST_SCAN: begin
            step_in  = step_ff + CNT_W'(1);
            found_in = found_ff || match;
            if (match && (kind_ff == REQ_REMOVE)) begin
               cmd.op   = CELL_DELETE;
               count_in = count_ff - CNT_W'(1);
            end else begin
               cmd.op   = CELL_ROTATE;
               cmd.refd = head.refd || (match && (kind_ff == REQ_INSERT));
            end
            if (last_step) begin
               if ((kind_ff == REQ_INSERT) && !(found_ff || match)) begin
                  if (cap_ok) begin
                     append_in = 1'b1;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in = ST_SWEEP;
                  end
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         // Second chance: clear and pass referenced entries, then overwrite or delete the head.
         ST_SWEEP: begin
            if (head.refd) begin
               cmd.op   = CELL_ROTATE;
               cmd.refd = 1'b0;
            end else begin
               if (kind_ff == REQ_VICTIM) begin
                  cmd.op    = CELL_DELETE;
                  vframe_in = head.frame;
                  vvalid_in = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  cmd.op   = CELL_OVERWRITE;
                  cmd.refd = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               if (append_ff) begin
                  cmd.op   = CELL_APPEND;
                  count_in = count_ff + CNT_W'(1);
               end
               rsp_valid_in   = 1'b1;
               rsp_frame_in   = vframe_ff;
               rsp_vvalid_in  = vvalid_ff;
               rsp_present_in = found_ff;
               rsp_occ_in     = append_ff ? OCC_W'(count_ff + CNT_W'(1)) : OCC_W'(count_ff);
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      n_ff           <= n_in;
      step_ff        <= step_in;
      found_ff       <= found_in;
      append_ff      <= append_in;
      vframe_ff      <= vframe_in;
      vvalid_ff      <= vvalid_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_vvalid_ff  <= rsp_vvalid_in;
      rsp_present_ff <= rsp_present_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_frame = rsp_frame_ff;
   assign rsp_victim_valid = rsp_vvalid_ff;
   assign rsp_was_present  = rsp_present_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign status.busy      = (state_ff != ST_IDLE);
   assign status.count     = count_ff;

endmodule

`default_nettype wire

[rtl/clock_page_replacement_core.sv]
// Sequence: a request is taken in idle; insert and remove scan a full lap of
//   the n current entries, the hand sweep visits up to n+1 entries, and a
//   finish state answers once the output is free. One transaction at a time.
// The scan and sweep rate is set by the single head cell, one entry per cycle.
// Reset (synchronous, active high): empty ring, hand at head, capacity 64.
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// Clock (second-chance) page replacer built as a row of shifting cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clock_page_replacement_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [crp_pkg::TYPE_W-1:0]  req_type,
   input  wire logic [crp_pkg::FRAME_W-1:0] req_frame_id,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [crp_pkg::FRAME_W-1:0]      rsp_victim_frame,
   output logic                             rsp_victim_valid,
   output logic                             rsp_was_present,
   output logic [crp_pkg::OCC_W-1:0]        rsp_occupancy,
   input  wire logic                        csr_wr_en,
   input  wire logic [crp_pkg::CAP_W-1:0]   csr_wr_data
);
   import crp_pkg::*;

   // The ring is kept in hand order: cell 0 is always the entry under the
   // hand, cell 1 the one after it, and so on; occupied cells are packed at
   // the low end. Moving the hand is a rotate: every occupied cell takes its
   // upper neighbor and the last occupied cell takes the old head. Slot
   // numbers of a linked-list layout are never visible, so order alone is
   // kept.
   //
   // Lookup runs as a full lap of rotations while the sequencer compares the
   // head against the requested id. A lap of n steps brings the original
   // head back to cell 0. A touch sets the reference bit as the hit entry
   // passes to the tail; a remove replaces that rotate with a delete (row
   // shifts down, tail empties), and the remaining n-1-k rotations of the
   // shorter ring land the hand on the removed entry's successor when the
   // head itself was removed.
   //
   // A new id goes just before the hand, which is simply the first free
   // cell. The sweep rotates while the head is referenced, clearing the bit
   // on the way to the tail; a full insert then overwrites the head, and a
   // victim transaction deletes it.

   crp_entry_type  cell_q     [NUM_SLOTS];
   crp_entry_type  next_entry [NUM_SLOTS];
   logic           prev_valid [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_vec;
   crp_cmd_type    cmd;
   crp_status_type status;

   crp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_frame_id     (req_frame_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_victim_frame (rsp_victim_frame),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_was_present  (rsp_was_present),
      .rsp_occupancy    (rsp_occupancy),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .head             (cell_q[0]),
      .cmd              (cmd),
      .status           (status)
   );

   // Neighbor wiring: each cell sees the cell above it and whether the cell
   // below it is occupied. The top cell sees an empty neighbor; cell 0 acts
   // as if something below it is occupied so it takes the first append.
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      if (i == NUM_SLOTS - 1) begin : g_top
         assign next_entry[i] = '0;
      end else begin : g_mid
         assign next_entry[i] = cell_q[i+1];
      end
      if (i == 0) begin : g_head
         assign prev_valid[i] = 1'b1;
      end else begin : g_rest
         assign prev_valid[i] = cell_q[i-1].valid;
      end
      assign valid_vec[i] = cell_q[i].valid;

      crp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .head       (cell_q[0]),
         .next       (next_entry[i]),
         .prev_valid (prev_valid[i]),
         .head_sel   (i == 0),
         .entry      (cell_q[i])
      );
   end

   // Occupied cells and the sequencer's count must agree.
   `ASSERT_ALWAYS(a_count_matches_cells, clock, reset, $countones(valid_vec) == int'(status.count))
   // Occupied cells stay packed at the low end of the row.
   `ASSERT_ALWAYS(a_cells_packed, clock, reset, ((valid_vec >> 1) & ~valid_vec) == '0)
   // An accepted transaction always takes the sequencer out of idle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, status.busy)
   // A victim result never also reports a found id.
   `ASSERT_IMPLY(a_victim_excl, clock, reset, rsp_valid && rsp_victim_valid, !rsp_was_present)

endmodule

`default_nettype wire
